### rtl/gregorian_to_hijri_date_defines.svh
// Assertion macros shared by the date converter RTL.
`ifndef GREGORIAN_TO_HIJRI_DATE_DEFINES_SVH
`define GREGORIAN_TO_HIJRI_DATE_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define G2H_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define G2H_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/g2h_pkg.sv
// Types, constants and month tables of the civil to Hijri date converter.
package g2h_pkg;

   // Pipeline depth of each datapath section.
   localparam int DaynumStages = 3;
   localparam int YearStages   = 4;
   localparam int MdayStages   = 7;
   localparam int PipeStages   = DaynumStages + YearStages + MdayStages;

   // Calendar switch date.
   localparam int SwitchYear  = 1582;
   localparam int SwitchMonth = 10;
   localparam int SwitchDay   = 15;
   localparam int MarchMonth  = 3;

   // Day number arithmetic.
   localparam int GregYearBias = 4800;
   localparam int GregCentBias = 4900;
   localparam int YearDaysX4   = 1461;
   localparam int CentLeapMul  = 3;
   localparam int CentYears    = 100;
   localparam int JdGregBias   = 32075;
   localparam int JulYearBias  = 5001;
   localparam int JulYearDays  = 367;
   localparam int JulLeapMul   = 7;
   localparam int JdJulBias    = 1729777;

   // Tabular Islamic cycle arithmetic.
   localparam int EpochJd     = 1948440;
   localparam int CycleBias   = 10632;
   localparam int CycleDays   = 10631;
   localparam int YearBias    = 354;
   localparam int CycleTail   = 10985;
   localparam int TailDiv     = 5316;
   localparam int OddMul      = 50;
   localparam int OddDiv      = 17719;
   localparam int HalfDiv     = 5670;
   localparam int EvenMul     = 43;
   localparam int EvenDiv     = 15238;
   localparam int CycleYears  = 30;
   localparam int OddYears    = 15;
   localparam int DayBias     = 29;
   localparam int MonthMul    = 24;
   localparam int MonthDiv    = 709;

   typedef struct packed {
      logic [13:0] civil_year;
      logic [3:0]  civil_month;
      logic [4:0]  civil_day;
   } g2h_req_type;

   typedef struct packed {
      logic [13:0] hijri_year;
      logic [3:0]  hijri_month;
      logic [4:0]  hijri_day;
   } g2h_rsp_type;

   // Day number section to year section: cycle index and day offset minus one.
   typedef struct packed {
      logic signed [10:0] cyc;
      logic signed [24:0] x;
   } g2h_day_type;

   // Year section to month/day section.
   typedef struct packed {
      logic signed [10:0] cyc;
      logic signed [14:0] r2;
      logic signed [8:0]  yr;
   } g2h_yr_type;

   // Gregorian month offset: 367 * (month shifted to start in March) / 12.
   function automatic logic [8:0] greg_month_days(input logic [3:0] month);
      logic [8:0] days;
      unique case (month)
         4'd0:  days = 9'd305;
         4'd1:  days = 9'd336;
         4'd2:  days = 9'd367;
         4'd3:  days = 9'd30;
         4'd4:  days = 9'd61;
         4'd5:  days = 9'd91;
         4'd6:  days = 9'd122;
         4'd7:  days = 9'd152;
         4'd8:  days = 9'd183;
         4'd9:  days = 9'd214;
         4'd10: days = 9'd244;
         4'd11: days = 9'd275;
         4'd12: days = 9'd305;
         4'd13: days = 9'd336;
         4'd14: days = 9'd367;
         4'd15: days = 9'd397;
      endcase
      return days;
   endfunction

   // Julian month offset: 275 * month / 9.
   function automatic logic [8:0] jul_month_days(input logic [3:0] month);
      logic [8:0] days;
      unique case (month)
         4'd0:  days = 9'd0;
         4'd1:  days = 9'd30;
         4'd2:  days = 9'd61;
         4'd3:  days = 9'd91;
         4'd4:  days = 9'd122;
         4'd5:  days = 9'd152;
         4'd6:  days = 9'd183;
         4'd7:  days = 9'd213;
         4'd8:  days = 9'd244;
         4'd9:  days = 9'd275;
         4'd10: days = 9'd305;
         4'd11: days = 9'd336;
         4'd12: days = 9'd366;
         4'd13: days = 9'd397;
         4'd14: days = 9'd427;
         4'd15: days = 9'd458;
      endcase
      return days;
   endfunction

endpackage

### rtl/g2h_cdiv.sv
// Signed division by a constant, truncating toward zero, by reciprocal multiply.
module g2h_cdiv #(
   parameter int Width   = 16,
   parameter int Divisor = 3
) (
   input  logic signed [Width-1:0] dividend,
   output logic signed [Width-1:0] quotient
);

   // Reciprocal rounded up, exact for every magnitude below 2**Width.
   localparam int          Shift       = Width + $clog2(Divisor);
   localparam int          MagicW      = Width + 2;
   localparam int          ProdW       = Width + MagicW;
   localparam logic [63:0] DivisorWide = 64'(Divisor);
   localparam logic [63:0] Magic       = ((64'd1 << Shift) + DivisorWide - 64'd1) / DivisorWide;

   logic [Width-1:0] mag;
   logic [ProdW-1:0] prod;
   logic [Width-1:0] qmag;

   assign mag      = dividend[Width-1] ? Width'(-dividend) : Width'(dividend);
   assign prod     = ProdW'(mag) * ProdW'(Magic[MagicW-1:0]);
   assign qmag     = Width'(prod >> Shift);
   assign quotient = dividend[Width-1] ? $signed(-qmag) : $signed(qmag);

endmodule

### rtl/g2h_daynum.sv
// Day number section: civil date to day offset and 30-year cycle index.
module g2h_daynum (
   input  logic                                 clock,
   input  logic [g2h_pkg::DaynumStages-1:0]     adv,
   input  g2h_pkg::g2h_req_type                 req,
   output g2h_pkg::g2h_day_type                 day
);
   import g2h_pkg::*;

   // Stage 1: branch select, year products, month table.
   logic        early;
   logic        greg_in, greg_ff;
   logic [14:0] ygreg;
   logic [15:0] ycent;
   logic [14:0] yjul;
   logic signed [15:0] cent_q;
   logic [24:0] g1prod_in, g1prod_ff;
   logic [7:0]  q100_in, q100_ff;
   logic [22:0] j1_in, j1_ff;
   logic [17:0] j2_in, j2_ff;
   logic [8:0]  mtab_in, mtab_ff;
   logic [4:0]  day_ff;

   // Stage 2: day number minus epoch.
   logic [9:0]  q3;
   logic [24:0] jd_greg, jd_jul, jd;
   logic signed [24:0] x_in, x_ff;

   // Stage 3: cycle index.
   logic signed [24:0] cyc_q;
   logic signed [10:0] cyc_in, cyc_ff;
   logic signed [24:0] x2_ff;

   always_comb begin
      early = req.civil_month < 4'(MarchMonth);
      greg_in = (req.civil_year > 14'(SwitchYear)) ||
                ((req.civil_year == 14'(SwitchYear)) &&
                 ((req.civil_month > 4'(SwitchMonth)) ||
                  ((req.civil_month == 4'(SwitchMonth)) &&
                   (req.civil_day >= 5'(SwitchDay)))));
      ygreg     = 15'(req.civil_year) + 15'(GregYearBias) - 15'(early);
      ycent     = 16'(req.civil_year) + 16'(GregCentBias) - 16'(early);
      yjul      = 15'(req.civil_year) + 15'(JulYearBias) - 15'(early);
      g1prod_in = 25'(ygreg) * 25'(YearDaysX4);
      j1_in     = 23'(req.civil_year) * 23'(JulYearDays);
      j2_in     = 18'((18'(yjul) * 18'(JulLeapMul)) >> 2);
      mtab_in   = greg_in ? greg_month_days(req.civil_month)
                          : jul_month_days(req.civil_month);
   end

   g2h_cdiv #(.Width(16), .Divisor(CentYears)) u_cent_div (
      .dividend ($signed(ycent)),
      .quotient (cent_q)
   );

   assign q100_in = cent_q[7:0];

   always_comb begin
      q3      = 10'(q100_ff) * 10'(CentLeapMul);
      jd_greg = 25'(g1prod_ff >> 2) + 25'(mtab_ff) + 25'(day_ff)
              - 25'(q3 >> 2) - 25'(JdGregBias);
      jd_jul  = 25'(j1_ff) - 25'(j2_ff) + 25'(mtab_ff) + 25'(day_ff) + 25'(JdJulBias);
      jd      = greg_ff ? jd_greg : jd_jul;
      x_in    = $signed(jd - 25'(EpochJd) + 25'(CycleBias) - 25'd1);
   end

   g2h_cdiv #(.Width(25), .Divisor(CycleDays)) u_cycle_div (
      .dividend (x_ff),
      .quotient (cyc_q)
   );

   assign cyc_in = $signed(cyc_q[10:0]);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         greg_ff   <= greg_in;
         g1prod_ff <= g1prod_in;
         q100_ff   <= q100_in;
         j1_ff     <= j1_in;
         j2_ff     <= j2_in;
         mtab_ff   <= mtab_in;
         day_ff    <= req.civil_day;
      end
      if (adv[1]) begin
         x_ff <= x_in;
      end
      if (adv[2]) begin
         cyc_ff <= cyc_in;
         x2_ff  <= x_ff;
      end
   end

   assign day.cyc = cyc_ff;
   assign day.x   = x2_ff;

endmodule

### rtl/g2h_year.sv
// Year section: day of cycle and year within the 30-year cycle.
module g2h_year (
   input  logic                               clock,
   input  logic [g2h_pkg::YearStages-1:0]     adv,
   input  g2h_pkg::g2h_day_type               day,
   output g2h_pkg::g2h_yr_type                yrs
);
   import g2h_pkg::*;

   logic signed [14:0] r2_in, r2_s4_ff, r2_s5_ff, r2_s6_ff, r2_s7_ff;
   logic signed [10:0] cyc_s4_ff, cyc_s5_ff, cyc_s6_ff, cyc_s7_ff;
   logic signed [20:0] p50_in, p50_ff, p43_in, p43_ff;
   logic signed [15:0] n_in, n_ff;
   logic signed [15:0] ya_q;
   logic signed [20:0] yb_q, yd_q;
   logic signed [14:0] yc_q;
   logic signed [2:0]  ya_in, ya_ff;
   logic signed [6:0]  yb_in, yb_ff, yd_in, yd_ff;
   logic signed [1:0]  yc_in, yc_ff;
   logic signed [8:0]  yr_in, yr_ff;

   // Remainder within the cycle, shifted by one Hijri year.
   assign r2_in = 15'(day.x - 25'(day.cyc) * 25'(CycleDays) + 25'(YearBias + 1));

   assign p50_in = 21'(r2_s4_ff) * 21'(OddMul);
   assign p43_in = 21'(r2_s4_ff) * 21'(EvenMul);
   assign n_in   = 16'(CycleTail) - 16'(r2_s4_ff);

   g2h_cdiv #(.Width(16), .Divisor(TailDiv)) u_tail_div (
      .dividend (n_ff),
      .quotient (ya_q)
   );

   g2h_cdiv #(.Width(21), .Divisor(OddDiv)) u_odd_div (
      .dividend (p50_ff),
      .quotient (yb_q)
   );

   g2h_cdiv #(.Width(15), .Divisor(HalfDiv)) u_half_div (
      .dividend (r2_s5_ff),
      .quotient (yc_q)
   );

   g2h_cdiv #(.Width(21), .Divisor(EvenDiv)) u_even_div (
      .dividend (p43_ff),
      .quotient (yd_q)
   );

   assign ya_in = $signed(ya_q[2:0]);
   assign yb_in = $signed(yb_q[6:0]);
   assign yc_in = $signed(yc_q[1:0]);
   assign yd_in = $signed(yd_q[6:0]);

   assign yr_in = 9'(ya_ff) * 9'(yb_ff) + 9'(yc_ff) * 9'(yd_ff);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         r2_s4_ff  <= r2_in;
         cyc_s4_ff <= day.cyc;
      end
      if (adv[1]) begin
         p50_ff    <= p50_in;
         p43_ff    <= p43_in;
         n_ff      <= n_in;
         r2_s5_ff  <= r2_s4_ff;
         cyc_s5_ff <= cyc_s4_ff;
      end
      if (adv[2]) begin
         ya_ff     <= ya_in;
         yb_ff     <= yb_in;
         yc_ff     <= yc_in;
         yd_ff     <= yd_in;
         r2_s6_ff  <= r2_s5_ff;
         cyc_s6_ff <= cyc_s5_ff;
      end
      if (adv[3]) begin
         yr_ff     <= yr_in;
         r2_s7_ff  <= r2_s6_ff;
         cyc_s7_ff <= cyc_s6_ff;
      end
   end

   assign yrs.cyc = cyc_s7_ff;
   assign yrs.r2  = r2_s7_ff;
   assign yrs.yr  = yr_ff;

endmodule

### rtl/g2h_mday.sv
// Month and day section: day of year to Hijri month and day, output register.
module g2h_mday (
   input  logic                               clock,
   input  logic [g2h_pkg::MdayStages-1:0]     adv,
   input  g2h_pkg::g2h_yr_type                yrs,
   output g2h_pkg::g2h_rsp_type               rsp
);
   import g2h_pkg::*;

   // Stage 8
   logic signed [8:0]  t_in, t_ff;
   logic signed [22:0] u_in, u_ff, v_in, v_ff;
   logic [13:0]        hy_in, hy_s8_ff, hy_s9_ff, hy_s10_ff, hy_s11_ff, hy_s12_ff, hy_s13_ff;
   logic signed [14:0] r2_s8_ff, r2_s9_ff;
   logic signed [8:0]  yr_s8_ff;
   // Stage 9
   logic signed [8:0]  e_q;
   logic signed [22:0] f_q, h_q;
   logic [8:0]         yr_mag;
   logic [4:0]         g_mag;
   logic signed [3:0]  e_in, e_ff, g_in, g_ff;
   logic signed [16:0] f_in, f_ff, h_in, h_ff;
   // Stage 10 to 13
   logic signed [21:0] r3_in, r3_s10_ff, r3_s11_ff, r3_s12_ff, r3_s13_ff;
   logic signed [25:0] p24_in, p24_ff;
   logic signed [25:0] hm_q;
   logic signed [15:0] hm_in, hm_s12_ff, hm_s13_ff;
   logic signed [25:0] m709_in, m709_ff;
   // Stage 14
   logic signed [25:0] q24;
   logic signed [21:0] hd;
   g2h_pkg::g2h_rsp_type rsp_in, rsp_ff;

   assign t_in  = 9'(CycleYears) - yrs.yr;
   assign u_in  = 23'(yrs.yr) * 23'(OddDiv);
   assign v_in  = 23'(yrs.yr) * 23'(EvenDiv);
   assign hy_in = 14'(14'(yrs.cyc) * 14'(CycleYears) + 14'(yrs.yr) - 14'(CycleYears));

   g2h_cdiv #(.Width(9), .Divisor(OddYears)) u_odd_years_div (
      .dividend (t_ff),
      .quotient (e_q)
   );

   g2h_cdiv #(.Width(23), .Divisor(OddMul)) u_odd_len_div (
      .dividend (u_ff),
      .quotient (f_q)
   );

   g2h_cdiv #(.Width(23), .Divisor(EvenMul)) u_even_len_div (
      .dividend (v_ff),
      .quotient (h_q)
   );

   // Truncate yr / 16 toward zero.
   always_comb begin
      yr_mag = yr_s8_ff[8] ? 9'(-yr_s8_ff) : 9'(yr_s8_ff);
      g_mag  = 5'(yr_mag >> 4);
      g_in   = yr_s8_ff[8] ? $signed(-4'(g_mag)) : $signed(4'(g_mag));
   end

   assign e_in = $signed(e_q[3:0]);
   assign f_in = $signed(f_q[16:0]);
   assign h_in = $signed(h_q[16:0]);

   assign r3_in = 22'(r2_s9_ff) - 22'(e_ff) * 22'(f_ff) - 22'(g_ff) * 22'(h_ff)
                + 22'(DayBias);

   assign p24_in = 26'(r3_s10_ff) * 26'(MonthMul);

   g2h_cdiv #(.Width(26), .Divisor(MonthDiv)) u_month_div (
      .dividend (p24_ff),
      .quotient (hm_q)
   );

   assign hm_in   = $signed(hm_q[15:0]);
   assign m709_in = 26'(hm_s12_ff) * 26'(MonthDiv);

   g2h_cdiv #(.Width(26), .Divisor(MonthMul)) u_day_div (
      .dividend (m709_ff),
      .quotient (q24)
   );

   always_comb begin
      hd                 = r3_s13_ff - 22'(q24);
      rsp_in.hijri_year  = hy_s13_ff;
      rsp_in.hijri_month = hm_s13_ff[3:0];
      rsp_in.hijri_day   = hd[4:0];
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         t_ff     <= t_in;
         u_ff     <= u_in;
         v_ff     <= v_in;
         hy_s8_ff <= hy_in;
         r2_s8_ff <= yrs.r2;
         yr_s8_ff <= yrs.yr;
      end
      if (adv[1]) begin
         e_ff     <= e_in;
         f_ff     <= f_in;
         g_ff     <= g_in;
         h_ff     <= h_in;
         r2_s9_ff <= r2_s8_ff;
         hy_s9_ff <= hy_s8_ff;
      end
      if (adv[2]) begin
         r3_s10_ff <= r3_in;
         hy_s10_ff <= hy_s9_ff;
      end
      if (adv[3]) begin
         p24_ff    <= p24_in;
         r3_s11_ff <= r3_s10_ff;
         hy_s11_ff <= hy_s10_ff;
      end
      if (adv[4]) begin
         hm_s12_ff <= hm_in;
         r3_s12_ff <= r3_s11_ff;
         hy_s12_ff <= hy_s11_ff;
      end
      if (adv[5]) begin
         m709_ff   <= m709_in;
         hm_s13_ff <= hm_s12_ff;
         r3_s13_ff <= r3_s12_ff;
         hy_s13_ff <= hy_s12_ff;
      end
      if (adv[6]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

### rtl/gregorian_to_hijri_date.sv
// Civil date (Gregorian from 15 Oct 1582, Julian before) to tabular Islamic
// date converter. One request enters per clock while req_stall is low; the 14
// register stages each hold about one multiplier, since every division by a
// constant is a reciprocal multiply or a shift. Each stage moves on when it
// or any stage ahead of it is empty, so empty slots close up while rsp_stall
// is high and req_stall rises only when all 14 stages hold requests and the
// result register is stalled. There is no state between requests and no
// configuration.
`include "gregorian_to_hijri_date_defines.svh"

module gregorian_to_hijri_date (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  g2h_pkg::g2h_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output g2h_pkg::g2h_rsp_type rsp_data
);
   import g2h_pkg::*;

   logic [PipeStages-1:0] valid_ff, valid_in, adv;
   g2h_day_type day;
   g2h_yr_type  yrs;

   // A stage advances when rsp_stall is low or any stage from it to the output is empty.
   for (genvar i = 0; i < PipeStages; i++) begin : g_adv
      assign adv[i] = !rsp_stall || !(&valid_ff[PipeStages-1:i]);
   end

   always_comb begin
      valid_in[0] = adv[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < PipeStages; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[PipeStages-1];

   g2h_daynum u_daynum (
      .clock (clock),
      .adv   (adv[DaynumStages-1:0]),
      .req   (req_data),
      .day   (day)
   );

   g2h_year u_year (
      .clock (clock),
      .adv   (adv[DaynumStages+YearStages-1:DaynumStages]),
      .day   (day),
      .yrs   (yrs)
   );

   g2h_mday u_mday (
      .clock (clock),
      .adv   (adv[PipeStages-1:DaynumStages+YearStages]),
      .yrs   (yrs),
      .rsp   (rsp_data)
   );

   `G2H_ASSERT_ALWAYS(a_empty_after_reset, clock, $past(reset) |-> valid_ff == '0, "pipeline not empty after reset")
   `G2H_ASSERT(a_occupancy, clock, reset, !$past(reset) |-> $countones(valid_ff) == $past($countones(valid_ff)) + $past(req_valid && !req_stall) - $past(rsp_valid && !rsp_stall), "request lost or duplicated in pipeline")
   `G2H_ASSERT(a_result_from_pipe, clock, reset, $rose(rsp_valid) |-> $past(valid_ff[PipeStages-2]), "result appeared without a request behind it")

endmodule
